[hw/rtl/mhb_pkg.sv]
// Shared constants, types and codes of the multidimensional histogram bin engine.
package mhb_pkg;

  localparam int unsigned MaxDims       = 4;
  localparam int unsigned DimW          = $clog2(MaxDims);
  localparam int unsigned BinW          = 8;
  localparam int unsigned RadixW        = BinW + 1;
  localparam int unsigned NdimsW        = 3;
  localparam int unsigned ValW          = 48;
  localparam int unsigned SumW          = 64;
  localparam int unsigned CntW          = 32;
  localparam int unsigned FlatW         = 12;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 8;
  localparam int unsigned DefStoreDepth = 4096;

  localparam logic [NdimsW-1:0] NdimsReset = NdimsW'(1);
  localparam logic [BinW-1:0]   BinsReset  = BinW'(14);

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef enum logic [1:0] {
    OpFill = 2'd0,
    OpSet  = 2'd1,
    OpGet  = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumDims   = 3'd0,
    CfgAxisBins0 = 3'd1,
    CfgAxisBins1 = 3'd2,
    CfgAxisBins2 = 3'd3,
    CfgAxisBins3 = 3'd4
  } cfg_idx_e;

  typedef logic [MaxDims-1:0][BinW-1:0] bins_vec_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_ctrl_t;

  typedef struct packed {
    logic done;
    logic bad;
  } idx_res_t;

endpackage

[hw/rtl/mhb_index.sv]
// Iterative mixed-radix flattening unit with one multiply-add per axis and range checking.
module mhb_index import mhb_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DefStoreDepth,
  localparam int unsigned AddrW = $clog2(STORE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NdimsW-1:0] num_dims_i,
  input  bins_vec_t         axis_bins_i,
  input  bins_vec_t         bin_index_i,
  output logic [AddrW-1:0]  flat_o,
  output idx_res_t          res_o
);

  localparam int unsigned ProdW = AddrW + RadixW + 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              bad_q, bad_d;
  logic [DimW-1:0]   dim_q, dim_d;
  logic [AddrW-1:0]  acc_q, acc_d;
  bins_vec_t         bidx_q, bidx_d;
  logic [DimW-1:0]   dim_first;
  logic [RadixW-1:0] radix;
  logic [BinW-1:0]   cur_bin;
  logic [ProdW-1:0]  prod;

  always_comb begin
    if (num_dims_i == '0) begin
      dim_first = '0;
    end else if (num_dims_i > NdimsW'(MaxDims)) begin
      dim_first = DimW'(MaxDims - 1);
    end else begin
      dim_first = DimW'(num_dims_i - 1'b1);
    end
  end

  assign radix   = {1'b0, axis_bins_i[dim_q]} + RadixW'(2);
  assign cur_bin = bidx_q[dim_q];
  assign prod    = ProdW'(acc_q) * ProdW'(radix) + ProdW'(cur_bin);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bad_d  = bad_q;
    dim_d  = dim_q;
    acc_d  = acc_q;
    bidx_d = bidx_q;
    if (start_i) begin
      busy_d = 1'b1;
      bad_d  = 1'b0;
      dim_d  = dim_first;
      acc_d  = '0;
      bidx_d = bin_index_i;
    end else if (busy_q) begin
      acc_d = prod[AddrW-1:0];
      // The partial index only grows, so exceeding the store early is final.
      if (({1'b0, cur_bin} >= radix) || (prod >= ProdW'(STORE_DEPTH))) begin
        bad_d = 1'b1;
      end
      if (dim_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        dim_d = dim_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bad_q  <= 1'b0;
      dim_q  <= '0;
      acc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bad_q  <= bad_d;
      dim_q  <= dim_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q <= bidx_d;
  end

  assign flat_o     = acc_q;
  assign res_o.done = done_q;
  assign res_o.bad  = bad_q;

endmodule

[hw/rtl/mhb_store.sv]
// Bin content memory with registered read data and a clearing sweep after reset.
module mhb_store import mhb_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DefStoreDepth,
  localparam int unsigned AddrW = $clog2(STORE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_ctrl_t        ctrl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [ValW-1:0]  wdata_i,
  output logic [ValW-1:0]  rdata_o,
  output logic             clear_busy_o
);

  logic [ValW-1:0]  mem [STORE_DEPTH];
  logic [ValW-1:0]  rdata_q;
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(STORE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (ctrl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o      = rdata_q;
  assign clear_busy_o = clr_busy_q;

endmodule

[hw/rtl/multidim_histogram_bin_engine_core.sv]
// Top level of the multidimensional histogram bin engine with fill, set and get of bins.
// One word is processed at a time: after acceptance the index unit does one multiply-add per axis,
// then the read, modify and sum steps use the single memory port before the result is loaded
// into the output register; an out-of-range index skips the read, modify and sum steps.
// After reset the store is cleared, during which no word is accepted; configuration writes
// are taken at all times.
module multidim_histogram_bin_engine_core import mhb_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DefStoreDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [BinW-1:0]            bin_index_0_i,
  input  logic [BinW-1:0]            bin_index_1_i,
  input  logic [BinW-1:0]            bin_index_2_i,
  input  logic [BinW-1:0]            bin_index_3_i,
  input  logic signed [ValW-1:0]     value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [FlatW-1:0]           flat_index_o,
  output logic signed [ValW-1:0]     content_o,
  output logic signed [SumW-1:0]     running_sum_o,
  output logic [CntW-1:0]            fills_done_o,
  output logic                       status_o
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INDEX,
    S_READ,
    S_MODIFY,
    S_SUM,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [ValW-1:0]   value_q, value_d;
  logic              bad_q, bad_d;
  logic [ValW-1:0]   nw_q, nw_d;
  logic [ValW:0]     delta_q, delta_d;
  logic [SumW-1:0]   total_q, total_d;
  logic [CntW-1:0]   fills_q, fills_d;
  logic [NdimsW-1:0] ndims_q, ndims_d;
  bins_vec_t         bins_q, bins_d;
  logic              out_valid_q, out_valid_d;
  logic [FlatW-1:0]  out_flat_q, out_flat_d;
  logic [ValW-1:0]   out_content_q, out_content_d;
  logic [SumW-1:0]   out_sum_q, out_sum_d;
  logic [CntW-1:0]   out_fills_q, out_fills_d;
  logic              out_status_q, out_status_d;

  bins_vec_t         bin_vec;
  logic              in_accept;
  logic              load_ok;
  logic              clear_busy;
  idx_res_t          idx_res;
  logic [AddrW-1:0]  idx_flat;
  mem_ctrl_t         mem_ctrl;
  logic [ValW-1:0]   old_val;
  logic [ValW:0]     fill_sum;
  logic [ValW-1:0]   fill_sat;
  logic [ValW-1:0]   nw;
  logic [SumW:0]     total_sum;
  logic [SumW-1:0]   total_sat;

  assign bin_vec    = {bin_index_3_i, bin_index_2_i, bin_index_1_i, bin_index_0_i};
  assign in_ready_o = (state_q == S_IDLE) && !clear_busy;
  assign in_accept  = in_valid_i && in_ready_o;
  assign load_ok    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  mhb_index #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .num_dims_i  (ndims_q),
    .axis_bins_i (bins_q),
    .bin_index_i (bin_vec),
    .flat_o      (idx_flat),
    .res_o       (idx_res)
  );

  mhb_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mem_ctrl),
    .addr_i       (idx_flat),
    .wdata_i      (nw),
    .rdata_o      (old_val),
    .clear_busy_o (clear_busy)
  );

  // Fill adds with saturation at the limits of the content range.
  assign fill_sum = {old_val[ValW-1], old_val} + {value_q[ValW-1], value_q};
  always_comb begin
    if (fill_sum[ValW] != fill_sum[ValW-1]) begin
      fill_sat = fill_sum[ValW] ? ValMin : ValMax;
    end else begin
      fill_sat = fill_sum[ValW-1:0];
    end
  end

  always_comb begin
    case (op_q)
      OpFill:  nw = fill_sat;
      OpSet:   nw = value_q;
      default: nw = old_val;
    endcase
  end

  assign total_sum = {total_q[SumW-1], total_q}
                   + {{(SumW-ValW){delta_q[ValW]}}, delta_q};
  always_comb begin
    if (total_sum[SumW] != total_sum[SumW-1]) begin
      total_sat = total_sum[SumW] ? SumMin : SumMax;
    end else begin
      total_sat = total_sum[SumW-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    value_d       = value_q;
    bad_d         = bad_q;
    nw_d          = nw_q;
    delta_d       = delta_q;
    total_d       = total_q;
    fills_d       = fills_q;
    ndims_d       = ndims_q;
    bins_d        = bins_q;
    out_valid_d   = out_valid_q;
    out_flat_d    = out_flat_q;
    out_content_d = out_content_q;
    out_sum_d     = out_sum_q;
    out_fills_d   = out_fills_q;
    out_status_d  = out_status_q;
    mem_ctrl      = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgNumDims:   ndims_d   = cfg_data_i[NdimsW-1:0];
        CfgAxisBins0: bins_d[0] = cfg_data_i;
        CfgAxisBins1: bins_d[1] = cfg_data_i;
        CfgAxisBins2: bins_d[2] = cfg_data_i;
        CfgAxisBins3: bins_d[3] = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d    = op_e'(opcode_i);
          value_d = value_i;
          state_d = S_INDEX;
        end
      end
      S_INDEX: begin
        if (idx_res.done) begin
          bad_d   = idx_res.bad;
          state_d = idx_res.bad ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        mem_ctrl.re = 1'b1;
        state_d     = S_MODIFY;
      end
      S_MODIFY: begin
        mem_ctrl.we = 1'b1;
        nw_d        = nw;
        delta_d     = {nw[ValW-1], nw} - {old_val[ValW-1], old_val};
        if ((op_q == OpFill) && (fills_q != '1)) begin
          fills_d = fills_q + 1'b1;
        end
        state_d = S_SUM;
      end
      S_SUM: begin
        total_d = total_sat;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (load_ok) begin
          out_valid_d   = 1'b1;
          out_flat_d    = bad_q ? '0 : FlatW'(idx_flat);
          out_content_d = bad_q ? '0 : nw_q;
          out_sum_d     = total_q;
          out_fills_d   = fills_q;
          out_status_d  = bad_q ? StatusRange : StatusOk;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OpGet;
      value_q       <= '0;
      bad_q         <= 1'b0;
      nw_q          <= '0;
      delta_q       <= '0;
      total_q       <= '0;
      fills_q       <= '0;
      ndims_q       <= NdimsReset;
      bins_q        <= {MaxDims{BinsReset}};
      out_valid_q   <= 1'b0;
      out_flat_q    <= '0;
      out_content_q <= '0;
      out_sum_q     <= '0;
      out_fills_q   <= '0;
      out_status_q  <= StatusOk;
    end else begin
      state_q       <= state_d;
      op_q          <= op_d;
      value_q       <= value_d;
      bad_q         <= bad_d;
      nw_q          <= nw_d;
      delta_q       <= delta_d;
      total_q       <= total_d;
      fills_q       <= fills_d;
      ndims_q       <= ndims_d;
      bins_q        <= bins_d;
      out_valid_q   <= out_valid_d;
      out_flat_q    <= out_flat_d;
      out_content_q <= out_content_d;
      out_sum_q     <= out_sum_d;
      out_fills_q   <= out_fills_d;
      out_status_q  <= out_status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign flat_index_o  = out_flat_q;
  assign content_o     = out_content_q;
  assign running_sum_o = out_sum_q;
  assign fills_done_o  = out_fills_q;
  assign status_o      = out_status_q;

  a_idx_done_in_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_res.done |-> state_q == S_INDEX)
    else $error("Index unit finished outside the index step.");

  a_range_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == StatusRange) |-> (out_content_q == '0) && (out_flat_q == '0))
    else $error("Out-of-range word carries a non-zero bin or content.");

  a_fills_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fills_q >= $past(fills_q))
    else $error("Fill counter went backwards.");

  a_total_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(total_q) |-> $past(state_q) == S_SUM)
    else $error("Running sum changed outside the sum step.");

endmodule

[test/multidim_histogram_bin_engine_core_tb.sv]
// Self-checking testbench of the histogram bin engine: directed and random fill, set and get words.
module multidim_histogram_bin_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mhb_pkg::*;

  localparam logic [1:0]  OpSpareGet     = 2'd3;
  localparam int unsigned NumRegs        = int'(CfgAxisBins3) + 1;
  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned LongHoldCycles = 300;

  typedef struct {
    logic [FlatW-1:0]       flat;
    logic signed [ValW-1:0] content;
    logic signed [SumW-1:0] total;
    logic [CntW-1:0]        fills;
    logic                   status;
  } bin_reply_t;

  class histogram_shadow;
    logic signed [ValW-1:0] cells [DefStoreDepth];
    logic signed [SumW-1:0] total;
    logic [CntW-1:0]        fills;
    logic [NdimsW-1:0]      ndims;
    bins_vec_t              axis_bins;
    bin_reply_t             replies_due [$];
    int unsigned            mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      total      = '0;
      fills      = '0;
      ndims      = NdimsReset;
      axis_bins  = {MaxDims{BinsReset}};
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      if (idx == CfgNumDims) begin
        ndims = data[NdimsW-1:0];
      end else begin
        axis_bins[idx - CfgAxisBins0] = data;
      end
    endfunction

    // Works out the reply to one accepted word and updates the shadow store.
    function void apply_word(logic [1:0] op, bins_vec_t bi, logic [ValW-1:0] val);
      int unsigned         used;
      longint unsigned     flat;
      longint unsigned     radix;
      bit                  bad;
      longint              old_c;
      longint              new_c;
      longint              weight;
      longint              hi;
      longint              lo;
      logic signed [SumW:0] wide;
      bin_reply_t          r;
      used = (ndims == 0) ? 1 : (ndims > MaxDims) ? MaxDims : ndims;
      flat = 0;
      bad  = 1'b0;
      for (int d = int'(used) - 1; d >= 0; d--) begin
        radix = longint'(axis_bins[d]) + 2;
        if (bi[d] >= radix) bad = 1'b1;
        flat = flat * radix + bi[d];
      end
      if (flat >= DefStoreDepth) bad = 1'b1;
      if (bad) begin
        r.flat    = '0;
        r.content = '0;
        r.status  = StatusRange;
      end else begin
        old_c  = cells[flat];
        weight = $signed(val);
        hi     = $signed(ValMax);
        lo     = $signed(ValMin);
        new_c  = old_c;
        if (op == OpFill) begin
          new_c = old_c + weight;
          if (new_c > hi) new_c = hi;
          if (new_c < lo) new_c = lo;
          if (fills != '1) fills++;
        end else if (op == OpSet) begin
          new_c = weight;
        end
        cells[flat] = new_c[ValW-1:0];
        wide = total + (new_c - old_c);
        if (wide[SumW] != wide[SumW-1]) begin
          total = wide[SumW] ? SumMin : SumMax;
        end else begin
          total = wide[SumW-1:0];
        end
        r.flat    = flat[FlatW-1:0];
        r.content = new_c[ValW-1:0];
        r.status  = StatusOk;
      end
      r.total = total;
      r.fills = fills;
      replies_due.push_back(r);
    endfunction

    function void flag(string field, longint want, longint got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void match_reply(bin_reply_t got);
      bin_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: result word arrived with no word outstanding", $time);
        return;
      end
      want = replies_due.pop_front();
      if (got.flat !== want.flat) flag("flat_index", want.flat, got.flat);
      if (got.content !== want.content) flag("content", want.content, got.content);
      if (got.total !== want.total) flag("running_sum", want.total, got.total);
      if (got.fills !== want.fills) flag("fills_done", want.fills, got.fills);
      if (got.status !== want.status) flag("status", want.status, got.status);
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             opcode_i;
  logic [BinW-1:0]        bin_index_0_i;
  logic [BinW-1:0]        bin_index_1_i;
  logic [BinW-1:0]        bin_index_2_i;
  logic [BinW-1:0]        bin_index_3_i;
  logic signed [ValW-1:0] value_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [FlatW-1:0]       flat_index_o;
  logic signed [ValW-1:0] content_o;
  logic signed [SumW-1:0] running_sum_o;
  logic [CntW-1:0]        fills_done_o;
  logic                   status_o;

  histogram_shadow shadow = new();
  bin_reply_t      seen;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  bit              long_hold_req = 1'b0;

  multidim_histogram_bin_engine_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .bin_index_0_i (bin_index_0_i),
    .bin_index_1_i (bin_index_1_i),
    .bin_index_2_i (bin_index_2_i),
    .bin_index_3_i (bin_index_3_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .flat_index_o  (flat_index_o),
    .content_o     (content_o),
    .running_sum_o (running_sum_o),
    .fills_done_o  (fills_done_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      seen.flat    = flat_index_o;
      seen.content = content_o;
      seen.total   = running_sum_o;
      seen.fills   = fills_done_o;
      seen.status  = status_o;
      shadow.match_reply(seen);
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        hold_left = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input bins_vec_t bi,
                           input logic [ValW-1:0] val);
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    bin_index_0_i <= bi[0];
    bin_index_1_i <= bi[1];
    bin_index_2_i <= bi[2];
    bin_index_3_i <= bi[3];
    value_i       <= val;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    shadow.apply_word(op, bi, val);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [NdimsW-1:0] nd, input bins_vec_t bv);
    logic [CfgDataW-1:0] data [NumRegs];
    data[0] = CfgDataW'(nd);
    for (int d = 0; d < MaxDims; d++) data[d + 1] = bv[d];
    for (int r = 0; r < NumRegs; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(r);
      cfg_data_i  <= data[r];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      shadow.write_reg(cfg_idx_e'(r), data[r]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_word(input int unsigned used, input bins_vec_t bv);
    logic [1:0]      op;
    bins_vec_t       bi;
    logic [ValW-1:0] val;
    logic [BinW-1:0] top;
    int unsigned     roll;
    int unsigned     hot;
    roll = $urandom_range(0, 99);
    if (roll < 45) op = OpFill;
    else if (roll < 65) op = OpSet;
    else if (roll < 90) op = OpGet;
    else op = OpSpareGet;
    roll = $urandom_range(0, 99);
    hot  = $urandom_range(0, 3);
    for (int d = 0; d < MaxDims; d++) begin
      top = (bv[d] == '1) ? '1 : bv[d] + 1'b1;
      if (d >= used || roll < 15) bi[d] = BinW'($urandom_range(0, 255));
      else if (hot == 0) bi[d] = '0;
      else if (hot == 1) bi[d] = top;
      else bi[d] = BinW'($urandom_range(0, top));
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      val = ValW'(int'($urandom_range(0, 8191)) - 4096);
    end else if (roll < 65) begin
      val = $urandom_range(0, 1) ? ValMax - ValW'($urandom_range(0, 255))
                                 : ValMin + ValW'($urandom_range(0, 255));
    end else begin
      val = ValW'({$urandom(), $urandom()});
    end
    send_word(op, bi, val);
  endtask

  task automatic run_phase(input logic [NdimsW-1:0] nd, input bins_vec_t bv,
                           input int unsigned words, input int unsigned idle_pct,
                           input bit hold_first);
    int unsigned used;
    drain();
    configure(nd, bv);
    used = (nd == 0) ? 1 : (nd > MaxDims) ? MaxDims : nd;
    tx_idle_pct = idle_pct;
    rx_idle_pct = idle_pct;
    if (hold_first) long_hold_req = 1'b1;
    repeat (words) begin
      send_random_word(used, bv);
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
        idle_sender($urandom_range(1, 10));
      end
    end
  endtask

  initial begin : stimulus
    bins_vec_t         bv;
    logic [NdimsW-1:0] nd;
    int unsigned       used;
    int unsigned       lim;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgNumDims;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    opcode_i      <= OpFill;
    bin_index_0_i <= '0;
    bin_index_1_i <= '0;
    bin_index_2_i <= '0;
    bin_index_3_i <= '0;
    value_i       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: one axis of 14 bins, so 15 is the overflow bin and 16 lies beyond it.
    send_word(OpFill, {8'd255, 8'd255, 8'd255, 8'd0}, ValW'(256));
    send_word(OpFill, {24'd0, 8'd15}, ValW'(-128));
    send_word(OpGet, {24'd0, 8'd16}, '0);
    send_word(OpSet, {24'd0, 8'd255}, ValW'(5));
    send_word(OpSet, {24'd0, 8'd3}, ValMax);
    send_word(OpFill, {24'd0, 8'd3}, ValW'(1));
    send_word(OpSet, {24'd0, 8'd4}, ValMin);
    send_word(OpFill, {24'd0, 8'd4}, ValMin);
    send_word(OpGet, {24'd0, 8'd4}, '1);
    send_word(OpSpareGet, {24'd0, 8'd3}, ValW'(77));
    send_word(OpFill, {24'd0, 8'd7}, '1);
    send_word(OpSet, {24'd0, 8'd3}, '0);
    send_word(OpFill, {8'hAA, 8'h55, 8'hAA, 8'd0}, '0);

    run_phase(3'd1, {4{8'd254}}, 100, 20, 1'b0);
    run_phase(3'd2, {4{8'd62}}, 100, 30, 1'b0);
    run_phase(3'd3, {8'd200, 8'd14, 8'd14, 8'd14}, 100, 0, 1'b1);
    run_phase(3'd4, {4{8'd6}}, 120, 20, 1'b0);
    run_phase(3'd4, {4{8'd0}}, 60, 30, 1'b0);
    run_phase(3'd1, {4{8'd255}}, 60, 10, 1'b0);
    run_phase(3'd4, {4{8'd255}}, 60, 20, 1'b0);
    run_phase(3'd0, {8'd9, 8'd9, 8'd9, 8'd3}, 60, 10, 1'b0);
    run_phase(3'd7, {8'd2, 8'd3, 8'd4, 8'd5}, 80, 20, 1'b0);
    run_phase(3'd5, {4{8'd1}}, 60, 10, 1'b0);
    repeat (6) begin
      used = $urandom_range(1, MaxDims);
      nd   = NdimsW'(used);
      case (used)
        1: lim = 254;
        2: lim = 62;
        3: lim = 14;
        default: lim = 6;
      endcase
      for (int d = 0; d < MaxDims; d++) begin
        bv[d] = BinW'((d < used) ? $urandom_range(0, lim) : $urandom_range(0, 255));
      end
      run_phase(nd, bv, 60, 10 * $urandom_range(0, 3), 1'b0);
    end
    run_phase(3'd2, {4{8'd20}}, 100, 0, 1'b0);
    drain();

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("multidim_histogram_bin_engine_core_tb passed");
    end else begin
      $display("multidim_histogram_bin_engine_core_tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("multidim_histogram_bin_engine_core_tb failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/mhb_pkg.sv
hw/rtl/mhb_index.sv
hw/rtl/mhb_store.sv
hw/rtl/multidim_histogram_bin_engine_core.sv
test/multidim_histogram_bin_engine_core_tb.sv
